### hdl/dsu_pkg.sv
package dsu_pkg;

    // Default table depth
    localparam int NODES_DEFAULT = 256;

    // Operation codes carried on the op field
    typedef enum logic [1:0] {
        OP_FIND  = 2'd0,
        OP_UNION = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

endpackage

### hdl/dsu_link_ram.sv
module dsu_link_ram #(
    parameter int DEPTH = dsu_pkg::NODES_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    // Write one entry, register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/disjoint_set_union_engine_top.sv
// Union-find table over NODES elements, union by size with path compression.
// The table lives in one synchronous RAM (one read, one write port, registered
// read data); every operation is a sequence of RAM reads and write-backs,
// one item at a time. A find walks up from node_a to the root, restarts at
// node_a, re-points each walked node at the root and then closes out. A union
// runs both walks back to back; if the roots differ, it then writes the grown
// root and the absorbed root before the result is loaded. A clear sweeps the
// RAM one entry per cycle. in_ready rises in the cycle after the result is
// loaded. After reset the same sweep runs and in_ready stays low until it is
// done. A finished result sits in an output register, so the next beat is
// taken while it waits for out_ready. Indexes at or above NODES and the unused
// opcode change nothing and return all zeros.
module disjoint_set_union_engine_top #(
    parameter int NODES = dsu_pkg::NODES_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic [7:0] node_a,
    input  logic [7:0] node_b,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] root,
    output logic [8:0] set_size,
    output logic       merged
);

    import dsu_pkg::*;

    localparam int IW = $clog2(NODES);
    localparam int SW = $clog2(NODES + 1);
    localparam int EW = 1 + IW + SW;

    typedef struct packed {
        logic          is_root;
        logic [IW-1:0] parent;
        logic [SW-1:0] size;
    } entry_t;

    typedef enum logic [8:0] {
        S_CLR   = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_FRD   = 9'b000000100,
        S_FWALK = 9'b000001000,
        S_CRD   = 9'b000010000,
        S_CWALK = 9'b000100000,
        S_MKEEP = 9'b001000000,
        S_MDROP = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

    state_t        state_reg, state_next;
    op_t           op_reg, op_next;
    logic [IW-1:0] b_reg, b_next;
    logic [IW-1:0] start_reg, start_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] top_reg, top_next;
    logic [SW-1:0] tsize_reg, tsize_next;
    logic [IW-1:0] ra_reg, ra_next;
    logic [SW-1:0] sa_reg, sa_next;
    logic          phase_b_reg, phase_b_next;
    logic [IW-1:0] clr_idx_reg, clr_idx_next;
    logic          clr_op_reg, clr_op_next;
    logic [IW-1:0] res_root_reg, res_root_next;
    logic [SW-1:0] res_size_reg, res_size_next;
    logic          res_merged_reg, res_merged_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    root_reg, root_next;
    logic [8:0]    size_reg, size_next;
    logic          merged_reg, merged_next;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;
    entry_t        rd;

    logic          accept;
    logic          a_oob;
    logic          b_oob;
    logic          keep_b;
    logic [SW-1:0] size_sum;

    dsu_link_ram #(
        .DEPTH (NODES),
        .AW    (IW),
        .DW    (EW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign a_oob     = (32'(node_a) >= 32'(NODES));
    assign b_oob     = (32'(node_b) >= 32'(NODES));
    assign keep_b    = (sa_reg < tsize_reg);
    assign size_sum  = sa_reg + tsize_reg;

    assign out_valid = out_valid_reg;
    assign root      = root_reg;
    assign set_size  = size_reg;
    assign merged    = merged_reg;

    // Sequence one operation through the table RAM
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        b_next          = b_reg;
        start_next      = start_reg;
        cur_next        = cur_reg;
        top_next        = top_reg;
        tsize_next      = tsize_reg;
        ra_next         = ra_reg;
        sa_next         = sa_reg;
        phase_b_next    = phase_b_reg;
        clr_idx_next    = clr_idx_reg;
        clr_op_next     = clr_op_reg;
        res_root_next   = res_root_reg;
        res_size_next   = res_size_reg;
        res_merged_next = res_merged_reg;
        out_valid_next  = out_valid_reg;
        root_next       = root_reg;
        size_next       = size_reg;
        merged_next     = merged_reg;
        mem_we          = 1'b0;
        mem_waddr       = cur_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = start_reg;

        // Retire the output beat once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR:
            begin
                mem_we           = 1'b1;
                mem_waddr        = clr_idx_reg;
                mem_wdata        = '0;
                mem_wdata.is_root = 1'b1;
                mem_wdata.parent = clr_idx_reg;
                mem_wdata.size   = SW'(1);
                clr_idx_next     = clr_idx_reg + 1'b1;
                if (clr_idx_reg == IW'(NODES - 1))
                begin
                    state_next = clr_op_reg ? S_FIN : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = op_t'(op);
                    b_next          = IW'(node_b);
                    start_next      = IW'(node_a);
                    phase_b_next    = 1'b0;
                    res_root_next   = '0;
                    res_size_next   = '0;
                    res_merged_next = 1'b0;
                    unique case (op_t'(op))
                        OP_CLEAR:
                        begin
                            clr_idx_next = '0;
                            clr_op_next  = 1'b1;
                            state_next   = S_CLR;
                        end
                        OP_FIND:
                        begin
                            state_next = a_oob ? S_FIN : S_FRD;
                        end
                        OP_UNION:
                        begin
                            state_next = (a_oob || b_oob) ? S_FIN : S_FRD;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_FRD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = start_reg;
                cur_next   = start_reg;
                state_next = S_FWALK;
            end
            S_FWALK:
            begin
                // Climb one link per cycle until a root shows up
                if (rd.is_root)
                begin
                    top_next   = cur_reg;
                    tsize_next = rd.size;
                    state_next = S_CRD;
                end
                else
                begin
                    cur_next  = rd.parent;
                    mem_re    = 1'b1;
                    mem_raddr = rd.parent;
                end
            end
            S_CRD:
            begin
                if (start_reg == top_reg)
                begin
                    state_next = S_MKEEP;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = start_reg;
                    cur_next   = start_reg;
                    state_next = S_CWALK;
                end
            end
            S_CWALK:
            begin
                // Point the walked node at the root, fetch its old parent
                mem_we           = 1'b1;
                mem_waddr        = cur_reg;
                mem_wdata.is_root = 1'b0;
                mem_wdata.parent = top_reg;
                mem_wdata.size   = rd.size;
                if (rd.parent == top_reg)
                begin
                    state_next = S_MKEEP;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = rd.parent;
                    cur_next  = rd.parent;
                end
            end
            S_MKEEP:
            begin
                if (op_reg == OP_FIND)
                begin
                    res_root_next = top_reg;
                    res_size_next = tsize_reg;
                    state_next    = S_FIN;
                end
                else if (!phase_b_reg)
                begin
                    // First root found, go find the second
                    ra_next      = top_reg;
                    sa_next      = tsize_reg;
                    phase_b_next = 1'b1;
                    start_next   = b_reg;
                    state_next   = S_FRD;
                end
                else if (ra_reg == top_reg)
                begin
                    res_root_next = ra_reg;
                    res_size_next = sa_reg;
                    state_next    = S_FIN;
                end
                else
                begin
                    // Grow the larger root, tie keeps node_a's root
                    mem_we            = 1'b1;
                    mem_waddr         = keep_b ? top_reg : ra_reg;
                    mem_wdata.is_root = 1'b1;
                    mem_wdata.parent  = keep_b ? top_reg : ra_reg;
                    mem_wdata.size    = size_sum;
                    res_root_next     = keep_b ? top_reg : ra_reg;
                    res_size_next     = size_sum;
                    res_merged_next   = 1'b1;
                    cur_next          = keep_b ? ra_reg : top_reg;
                    tsize_next        = keep_b ? sa_reg : tsize_reg;
                    state_next        = S_MDROP;
                end
            end
            S_MDROP:
            begin
                mem_we            = 1'b1;
                mem_waddr         = cur_reg;
                mem_wdata.is_root = 1'b0;
                mem_wdata.parent  = res_root_reg;
                mem_wdata.size    = tsize_reg;
                state_next        = S_FIN;
            end
            S_FIN:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    root_next      = 8'(res_root_reg);
                    size_next      = (32'(res_size_reg) > 32'd511) ? 9'd511
                                                                   : 9'(res_size_reg);
                    merged_next    = res_merged_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_idx_reg   <= '0;
            clr_op_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            clr_op_reg    <= clr_op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        b_reg          <= b_next;
        start_reg      <= start_next;
        cur_reg        <= cur_next;
        top_reg        <= top_next;
        tsize_reg      <= tsize_next;
        ra_reg         <= ra_next;
        sa_reg         <= sa_next;
        phase_b_reg    <= phase_b_next;
        res_root_reg   <= res_root_next;
        res_size_reg   <= res_size_next;
        res_merged_reg <= res_merged_next;
        root_reg       <= root_next;
        size_reg       <= size_next;
        merged_reg     <= merged_next;
    end

    // A write never lands on the entry being read in the same cycle
    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("table read and write hit the same entry");

    // Compression only ever visits non-root nodes
    a_cwalk_nonroot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CWALK) |-> !rd.is_root)
        else $error("compression walk reached a root");

    // A real merge yields a set of at least two
    a_merge_size: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && merged) |-> (set_size >= 9'd2))
        else $error("merged beat with set size below two");

    // No beat is taken while the table sweep runs
    a_clr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !in_ready)
        else $error("input taken during table sweep");

endmodule

### sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dsu_pkg::*;

    localparam int NODES         = NODES_DEFAULT;
    localparam int RANDOM_ITEMS  = 700;
    localparam int PHASE_ITEMS   = RANDOM_ITEMS / 4;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = NODES + 32;

    typedef struct packed {
        logic [7:0] root;
        logic [8:0] set_size;
        logic       merged;
    } union_answer_t;

    // Mirror of the disjoint-set table plus the queue of answers still owed
    class set_table_tracker;
        bit            is_top[NODES];
        int unsigned   up[NODES];
        int unsigned   members[NODES];
        union_answer_t answers[$];
        int            errors;

        function new();
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (is_top[i])
            begin
                is_top[i]  = 1'b1;
                up[i]      = i;
                members[i] = 1;
            end
        endfunction

        // Walk up to the top, then re-point every walked node at it
        function int unsigned find_top(int unsigned start);
            int unsigned cur;
            int unsigned top;
            int unsigned nxt;
            int unsigned steps;
            cur = start;
            steps = 0;
            while (!is_top[cur] && steps < NODES)
            begin
                cur = up[cur] % NODES;
                steps++;
            end
            top = cur;
            cur = start;
            steps = 0;
            while (cur != top && !is_top[cur] && steps < NODES)
            begin
                nxt = up[cur] % NODES;
                up[cur] = top;
                cur = nxt;
                steps++;
            end
            return top;
        endfunction

        function logic [8:0] clipped_size(int unsigned r);
            return (members[r] > 511) ? 9'd511 : members[r][8:0];
        endfunction

        // Apply one accepted beat and queue the answer it must produce
        function void take_request(op_t code, logic [7:0] a, logic [7:0] b);
            union_answer_t ans;
            int unsigned   ra;
            int unsigned   rb;
            int unsigned   keep;
            int unsigned   gone;
            ans = '0;
            if (code == OP_CLEAR)
            begin
                wipe();
            end
            else if ((code == OP_FIND || code == OP_UNION) && a < NODES
                     && (code == OP_FIND || b < NODES))
            begin
                ra = find_top(a);
                if (code == OP_UNION)
                begin
                    rb = find_top(b);
                    if (ra != rb)
                    begin
                        // Larger set absorbs the smaller; a tie keeps node_a's top
                        keep = ra;
                        gone = rb;
                        if (members[ra] < members[rb])
                        begin
                            keep = rb;
                            gone = ra;
                        end
                        members[keep] = members[keep] + members[gone];
                        is_top[gone] = 1'b0;
                        up[gone] = keep;
                        ans.merged = 1'b1;
                        ra = keep;
                    end
                end
                ans.root = ra[7:0];
                ans.set_size = clipped_size(ra);
            end
            answers.insert(answers.size(), ans);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        // Compare one result beat with the oldest owed answer
        task check_answer(logic [7:0] r, logic [8:0] s, logic m);
            union_answer_t want;
            if (answers.size() == 0)
            begin
                report($sformatf("unexpected beat root=%0d set_size=%0d merged=%0d", r, s, m));
                return;
            end
            want = answers.pop_front();
            if (r !== want.root)
                report($sformatf("root %0d, want %0d", r, want.root));
            if (s !== want.set_size)
                report($sformatf("set_size %0d, want %0d", s, want.set_size));
            if (m !== want.merged)
                report($sformatf("merged %0d, want %0d", m, want.merged));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    op_t        op;
    logic [7:0] node_a;
    logic [7:0] node_b;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] root;
    logic [8:0] set_size;
    logic       merged;

    int cycles = 0;
    int send_gap_pct = 0;
    int ready_stall_pct = 0;

    set_table_tracker tracker = new();

    disjoint_set_union_engine_top #(
        .NODES(NODES)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .node_a   (node_a),
        .node_b   (node_b),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .root     (root),
        .set_size (set_size),
        .merged   (merged)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stall the result side at random
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // Watch both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tracker.take_request(op, node_a, node_b);
            if (out_valid && out_ready)
                tracker.check_answer(root, set_size, merged);
        end
    end

    // Drive one beat; entered and left at a falling edge, valid still high
    task send_beat(op_t code, logic [7:0] a, logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= code;
        node_a <= a;
        node_b <= b;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Drop valid and hold until every owed answer has arrived
    task wait_drained();
        in_valid <= 1'b0;
        while (tracker.answers.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        op_t        code;
        logic [7:0] a;
        logic [7:0] b;
        int         done;
        int         span;
        int         base;
        int         roll;
        int         pick;

        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_FIND;
        node_a = '0;
        node_b = '0;
        out_ready = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: field extremes, every op, tie and same-set unions, compression
        send_beat(OP_FIND, 8'd0, 8'd0);
        send_beat(OP_FIND, 8'd255, 8'd255);
        send_beat(OP_NONE, 8'd255, 8'd255);
        send_beat(OP_UNION, 8'd0, 8'd255);
        send_beat(OP_UNION, 8'd255, 8'd0);
        send_beat(OP_UNION, 8'd7, 8'd7);
        send_beat(OP_UNION, 8'd1, 8'd2);
        send_beat(OP_UNION, 8'd3, 8'd1);
        send_beat(OP_UNION, 8'd0, 8'd1);
        send_beat(OP_UNION, 8'd4, 8'd5);
        send_beat(OP_UNION, 8'd6, 8'd4);
        send_beat(OP_UNION, 8'd5, 8'd3);
        send_beat(OP_FIND, 8'd255, 8'd0);
        send_beat(OP_FIND, 8'd255, 8'd0);
        send_beat(OP_FIND, 8'd6, 8'd0);
        send_beat(OP_UNION, 8'd170, 8'd85);
        send_beat(OP_UNION, 8'd85, 8'd255);
        send_beat(OP_FIND, 8'd170, 8'd85);
        send_beat(OP_CLEAR, 8'd255, 8'd255);
        send_beat(OP_FIND, 8'd255, 8'd0);
        send_beat(OP_FIND, 8'd0, 8'd255);
        send_beat(OP_NONE, 8'd0, 8'd0);
        wait_drained();

        // Random: four phases of differing input gaps and output stalls, table built in windows of varying reach
        for (int phase = 0; phase < 4; phase++)
        begin
            send_gap_pct    = (phase == 1) ? 60 : (phase == 3) ? 6 : 0;
            ready_stall_pct = (phase == 2) ? 60 : (phase == 3) ? 6 : 0;
            done = 0;
            span = NODES;
            base = 0;
            while (done < PHASE_ITEMS)
            begin
                if (done % 50 == 0)
                begin
                    pick = $urandom_range(2);
                    span = (pick == 0) ? 8 : (pick == 1) ? 32 : NODES;
                    base = $urandom_range(NODES - span);
                end
                a = 8'(base + $urandom_range(span - 1));
                b = 8'(base + $urandom_range(span - 1));
                roll = $urandom_range(99);
                if (roll < 50)
                    code = OP_UNION;
                else if (roll < 95)
                    code = OP_FIND;
                else if (roll < 97)
                    code = OP_CLEAR;
                else
                begin
                    code = OP_NONE;
                    a = 8'($urandom_range(255));
                    b = 8'($urandom_range(255));
                end
                send_beat(code, a, b);
                if (code != OP_NONE)
                    done++;
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.answers.size() != 0)
            tracker.report($sformatf("%0d answers never arrived", tracker.answers.size()));
        if (tracker.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
